// File: design/tsph_pkg.sv
// Shared types, field widths and codes of the transport stream header formatter.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package tsph_pkg;

  localparam int PACKET_BYTES_DEF = 188;

  localparam int PID_W   = 13;
  localparam int SEL_W   = 2;
  localparam int CC_W    = 4;
  localparam int BASE_W  = 33;
  localparam int REM_W   = 24;
  localparam int BYTE_W  = 8;
  localparam int HDR_W   = 32;
  localparam int PCR_W   = 48;
  localparam int CFG_IDX_W = 2;
  localparam int STREAMS = 4;

  // action codes
  localparam logic ACT_EMIT    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // stream codes
  localparam logic [SEL_W-1:0] STREAM_PAT   = 2'd0;
  localparam logic [SEL_W-1:0] STREAM_PMT   = 2'd1;
  localparam logic [SEL_W-1:0] STREAM_VIDEO = 2'd2;
  localparam logic [SEL_W-1:0] STREAM_AUDIO = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PMT_PID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_PID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_PID = 2'd2;

  localparam logic [PID_W-1:0] PAT_PID       = 13'd0;
  localparam logic [PID_W-1:0] PMT_PID_RST   = 13'd4096;
  localparam logic [PID_W-1:0] VIDEO_PID_RST = 13'd256;
  localparam logic [PID_W-1:0] AUDIO_PID_RST = 13'd257;

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h47;
  localparam logic [BYTE_W-1:0] FLAGS_PCR  = 8'h10;
  localparam logic [BYTE_W-1:0] FLAGS_NONE = 8'h00;
  // flags byte plus six PCR bytes
  localparam int PCR_AF_BYTES = 7;
  localparam int HDR_BYTES    = 4;

  // adaptation field control codes
  localparam logic [1:0] AFC_PAYLOAD = 2'd1;
  localparam logic [1:0] AFC_ADAPT   = 2'd2;
  localparam logic [1:0] AFC_BOTH    = 2'd3;

  typedef struct packed {
    logic              action;
    logic [SEL_W-1:0]  stream_select;
    logic              unit_start;
    logic              carry_pcr;
    logic [BASE_W-1:0] clock_base;
    logic [REM_W-1:0]  bytes_remaining;
  } in_word_t;

  typedef struct packed {
    logic [HDR_W-1:0]  header_word;
    logic [BYTE_W-1:0] adapt_length;
    logic              adapt_present;
    logic [BYTE_W-1:0] adapt_flags;
    logic [PCR_W-1:0]  pcr_field;
    logic [BYTE_W-1:0] payload_start;
    logic [BYTE_W-1:0] payload_taken;
  } out_word_t;

  // control from the pipeline to the continuity counter bank
  typedef struct packed {
    logic             emit;
    logic             restart;
    logic [SEL_W-1:0] sel;
  } cc_ctl_t;

endpackage
`default_nettype wire

// File: design/tsph_in_if.sv
// Request channel: valid/ready handshake with the request fields.
// Depends on tsph_pkg for field widths.
`default_nettype none
interface tsph_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [tsph_pkg::SEL_W-1:0]  stream_select;
  logic                      unit_start;
  logic                      carry_pcr;
  logic [tsph_pkg::BASE_W-1:0] clock_base;
  logic [tsph_pkg::REM_W-1:0]  bytes_remaining;

  modport source (output valid, action, stream_select, unit_start, carry_pcr,
                  clock_base, bytes_remaining, input ready);
  modport sink   (input valid, action, stream_select, unit_start, carry_pcr,
                  clock_base, bytes_remaining, output ready);
endinterface
`default_nettype wire

// File: design/tsph_out_if.sv
// Result channel: valid/ready handshake with the formatted header fields.
// Depends on tsph_pkg for field widths.
`default_nettype none
interface tsph_out_if;
  logic                      valid;
  logic                      ready;
  logic [tsph_pkg::HDR_W-1:0]  header_word;
  logic [tsph_pkg::BYTE_W-1:0] adapt_length;
  logic                      adapt_present;
  logic [tsph_pkg::BYTE_W-1:0] adapt_flags;
  logic [tsph_pkg::PCR_W-1:0]  pcr_field;
  logic [tsph_pkg::BYTE_W-1:0] payload_start;
  logic [tsph_pkg::BYTE_W-1:0] payload_taken;

  modport source (output valid, header_word, adapt_length, adapt_present, adapt_flags,
                  pcr_field, payload_start, payload_taken, input ready);
  modport sink   (input valid, header_word, adapt_length, adapt_present, adapt_flags,
                  pcr_field, payload_start, payload_taken, output ready);
endinterface
`default_nettype wire

// File: design/tsph_cfg_regs.sv
// PID configuration registers and the stream-to-PID selection.
// Depends on tsph_pkg.
`default_nettype none
module tsph_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tsph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsph_pkg::PID_W-1:0]     cfg_data,
  input  wire logic [tsph_pkg::SEL_W-1:0]     sel,
  output logic      [tsph_pkg::PID_W-1:0]     pid
);

  logic [tsph_pkg::PID_W-1:0] pmt_pid_r, video_pid_r, audio_pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmt_pid_r   <= tsph_pkg::PMT_PID_RST;
      video_pid_r <= tsph_pkg::VIDEO_PID_RST;
      audio_pid_r <= tsph_pkg::AUDIO_PID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsph_pkg::REG_PMT_PID:   pmt_pid_r   <= cfg_data;
        tsph_pkg::REG_VIDEO_PID: video_pid_r <= cfg_data;
        tsph_pkg::REG_AUDIO_PID: audio_pid_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (sel)
      tsph_pkg::STREAM_PMT:   pid = pmt_pid_r;
      tsph_pkg::STREAM_VIDEO: pid = video_pid_r;
      tsph_pkg::STREAM_AUDIO: pid = audio_pid_r;
      default:                pid = tsph_pkg::PAT_PID;
    endcase
  end

endmodule
`default_nettype wire

// File: design/tsph_cc_bank.sv
// Per-stream continuity counters: read the selected one, advance on emit,
// clear all on restart. Depends on tsph_pkg.
`default_nettype none
module tsph_cc_bank (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tsph_pkg::cc_ctl_t         ctl,
  output logic      [tsph_pkg::CC_W-1:0] cc
);

  logic [tsph_pkg::CC_W-1:0] cc_r [tsph_pkg::STREAMS];

  assign cc = cc_r[ctl.sel];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      for (int i = 0; i < tsph_pkg::STREAMS; i++) cc_r[i] <= '0;
    end else if (ctl.emit) begin
      cc_r[ctl.sel] <= cc_r[ctl.sel] + tsph_pkg::CC_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: design/tsph_fmt.sv
// Header formatting logic: adaptation field sizing, payload split and
// header packing for one request. Depends on tsph_pkg.
`default_nettype none
module tsph_fmt #(
  parameter int PACKET_BYTES = tsph_pkg::PACKET_BYTES_DEF
) (
  input  wire tsph_pkg::in_word_t        req,
  input  wire logic [tsph_pkg::PID_W-1:0] pid,
  input  wire logic [tsph_pkg::CC_W-1:0]  cc,
  output tsph_pkg::out_word_t            res
);

  localparam int CAP = PACKET_BYTES - tsph_pkg::HDR_BYTES;
  localparam int PCR_CAP = CAP - tsph_pkg::PCR_AF_BYTES - 1;
  localparam logic [tsph_pkg::BYTE_W-1:0] CAP_B      = tsph_pkg::BYTE_W'(CAP);
  localparam logic [tsph_pkg::BYTE_W-1:0] PCR_CAP_B  = tsph_pkg::BYTE_W'(PCR_CAP);
  localparam logic [tsph_pkg::BYTE_W-1:0] AF_MAX_B   = tsph_pkg::BYTE_W'(CAP - 1);
  localparam logic [tsph_pkg::BYTE_W-1:0] PCR_AF_B   =
    tsph_pkg::BYTE_W'(tsph_pkg::PCR_AF_BYTES);
  localparam logic [tsph_pkg::BYTE_W-1:0] HDR_B      =
    tsph_pkg::BYTE_W'(tsph_pkg::HDR_BYTES);
  localparam logic [tsph_pkg::BYTE_W-1:0] AF_BASE_B  =
    tsph_pkg::BYTE_W'(tsph_pkg::HDR_BYTES + 1);

  logic                          short_unit, present;
  logic [tsph_pkg::BYTE_W-1:0]   rem_b, afl, offset, taken;
  logic [1:0]                    ctrl;

  assign rem_b = req.bytes_remaining[tsph_pkg::BYTE_W-1:0];

  always_comb begin
    // short: the remaining bytes no longer fill the payload space
    short_unit = req.carry_pcr ? (req.bytes_remaining < tsph_pkg::REM_W'(PCR_CAP))
                               : (req.bytes_remaining < tsph_pkg::REM_W'(CAP));
    present = req.carry_pcr | short_unit;
    if (short_unit)          afl = AF_MAX_B - rem_b;
    else if (req.carry_pcr)  afl = PCR_AF_B;
    else                     afl = '0;
    offset = present ? AF_BASE_B + afl : HDR_B;
    if (short_unit)          taken = rem_b;
    else if (req.carry_pcr)  taken = PCR_CAP_B;
    else                     taken = CAP_B;
    if (taken == '0)         ctrl = tsph_pkg::AFC_ADAPT;
    else if (present)        ctrl = tsph_pkg::AFC_BOTH;
    else                     ctrl = tsph_pkg::AFC_PAYLOAD;
  end

  always_comb begin
    res.header_word    = {tsph_pkg::SYNC_BYTE, 1'b0, req.unit_start, 1'b0, pid, 2'b00, ctrl,
                          cc};
    res.adapt_length   = afl;
    res.adapt_present  = present;
    res.adapt_flags    = req.carry_pcr ? tsph_pkg::FLAGS_PCR : tsph_pkg::FLAGS_NONE;
    res.pcr_field      = req.carry_pcr ?
                         {req.clock_base, (tsph_pkg::PCR_W - tsph_pkg::BASE_W)'(0)} : '0;
    res.payload_start  = offset;
    res.payload_taken  = taken;
  end

endmodule
`default_nettype wire

// File: design/ts_packet_header_formatter.sv
// Top level of the transport stream packet header formatter.
// Depends on tsph_pkg, tsph_in_if, tsph_out_if, tsph_cfg_regs, tsph_cc_bank, tsph_fmt.
//
// One request word per cycle is taken sustained while out_ch.ready stays high. A
// request waits in the input register; as it leaves, its stream's continuity
// counter is read and advanced and the header is formatted straight into the
// result register, from which its result word is driven on out_ch. A restart
// word clears all four counters as it leaves the input register and produces
// no result. The rate is set by the counter read-modify-write done as a word
// leaves; a stalled result holds the input register, which then holds in_ch.ready
// low. PID registers are to be written through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce this. Writes to an index beyond
// the three PID registers are dropped.
`default_nettype none
module ts_packet_header_formatter #(
  parameter int PACKET_BYTES = tsph_pkg::PACKET_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tsph_in_if.sink                             in_ch,
  tsph_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [tsph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tsph_pkg::PID_W-1:0]     cfg_data
);

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  tsph_pkg::in_word_t   s1_r;
  // result register
  logic                 out_valid_r, out_valid_nxt;
  tsph_pkg::out_word_t  out_r, fmt_res;

  logic                       in_accept, s1_adv, s1_emit, s1_restart;
  logic [tsph_pkg::PID_W-1:0] pid;
  logic [tsph_pkg::CC_W-1:0]  cc;
  tsph_pkg::cc_ctl_t          cc_ctl;

  // a restart leaves without a result; an emit needs room in the result register
  assign s1_restart = s1_r.action == tsph_pkg::ACT_RESTART;
  assign s1_adv     = s1_valid_r && (s1_restart || !out_valid_r || out_ch.ready);
  assign s1_emit    = s1_adv && !s1_restart;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept  = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load on accept / emit, otherwise hold
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r.action          <= in_ch.action;
      s1_r.stream_select   <= in_ch.stream_select;
      s1_r.unit_start      <= in_ch.unit_start;
      s1_r.carry_pcr       <= in_ch.carry_pcr;
      s1_r.clock_base      <= in_ch.clock_base;
      s1_r.bytes_remaining <= in_ch.bytes_remaining;
    end
    if (s1_emit) out_r <= fmt_res;
  end

  assign cc_ctl.emit    = s1_emit;
  assign cc_ctl.restart = s1_adv && s1_restart;
  assign cc_ctl.sel     = s1_r.stream_select;

  tsph_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sel       (s1_r.stream_select),
    .pid       (pid)
  );

  tsph_cc_bank u_cc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cc_ctl),
    .cc    (cc)
  );

  tsph_fmt #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_fmt (
    .req (s1_r),
    .pid (pid),
    .cc  (cc),
    .res (fmt_res)
  );

  // drive the result channel from the result register
  assign out_ch.valid          = out_valid_r;
  assign out_ch.header_word    = out_r.header_word;
  assign out_ch.adapt_length   = out_r.adapt_length;
  assign out_ch.adapt_present  = out_r.adapt_present;
  assign out_ch.adapt_flags    = out_r.adapt_flags;
  assign out_ch.pcr_field      = out_r.pcr_field;
  assign out_ch.payload_start  = out_r.payload_start;
  assign out_ch.payload_taken  = out_r.payload_taken;

endmodule
`default_nettype wire

// File: tb/ts_packet_header_formatter_tb.sv
// Self-checking testbench for the transport stream packet header formatter.
// Depends on tsph_pkg, tsph_in_if and tsph_out_if from the design folder.
// A table of directed requests runs first, then random phases under PID settings.
module ts_packet_header_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsph_pkg::*;

  localparam int PACKET_LEN = PACKET_BYTES_DEF;
  localparam int LONG_HOLD = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS = 400;
  localparam int HOLD_WORDS = 40;
  // writes here must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [PID_W-1:0] PID_MAX = 13'h1fff;

  // remaining-byte counts around every capacity boundary of the packet
  localparam int unsigned REM_EDGES [9] = '{0, 1, 175, 176, 177, 182, 183, 184, 185};

  // one row of stimulus: the request word and, where known up front, its header
  typedef struct packed {
    in_word_t  req;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 16;

  // Rows with typed = 1 carry the expected header; the rest go through the
  // header predictor. Restart rows produce no word.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // after reset: PAT, unit start, exactly one full payload
    '{'{ACT_EMIT, STREAM_PAT, 1'b1, 1'b0, 33'd0, 24'd184}, 1'b1,
      '{32'h4740_0010, 8'd0, 1'b0, 8'h00, 48'd0, 8'd4, 8'd184}},
    // PMT with nothing left: adaptation only, all stuffing
    '{'{ACT_EMIT, STREAM_PMT, 1'b0, 1'b0, 33'd0, 24'd0}, 1'b1,
      '{32'h4710_0020, 8'd183, 1'b1, 8'h00, 48'd0, 8'd188, 8'd0}},
    // video with PCR, largest base and largest remaining count
    '{'{ACT_EMIT, STREAM_VIDEO, 1'b1, 1'b1, 33'h1_ffff_ffff, 24'hff_ffff}, 1'b1,
      '{32'h4741_0030, 8'd7, 1'b1, 8'h10, 48'hffff_ffff_8000, 8'd12, 8'd176}},
    // audio with PCR and no payload: PCR plus stuffing fills the packet
    '{'{ACT_EMIT, STREAM_AUDIO, 1'b0, 1'b1, 33'd0, 24'd0}, 1'b1,
      '{32'h4701_0120, 8'd183, 1'b1, 8'h10, 48'd0, 8'd188, 8'd0}},
    // restart with every other field set: fields are ignored
    '{'{ACT_RESTART, STREAM_AUDIO, 1'b1, 1'b1, 33'h1_ffff_ffff, 24'hff_ffff}, 1'b0,
      '0},
    // one byte short of capacity: zero-length adaptation field
    '{'{ACT_EMIT, STREAM_PAT, 1'b0, 1'b0, 33'd0, 24'd183}, 1'b1,
      '{32'h4700_0030, 8'd0, 1'b1, 8'h00, 48'd0, 8'd5, 8'd183}},
    // single payload byte, maximum stuffing without PCR
    '{'{ACT_EMIT, STREAM_PAT, 1'b0, 1'b0, 33'd0, 24'd1}, 1'b1,
      '{32'h4700_0031, 8'd182, 1'b1, 8'h00, 48'd0, 8'd187, 8'd1}},
    // PCR around its capacity boundary
    '{'{ACT_EMIT, STREAM_VIDEO, 1'b0, 1'b1, 33'h1_5555_5555, 24'd175}, 1'b0, '0},
    '{'{ACT_EMIT, STREAM_VIDEO, 1'b1, 1'b1, 33'h0_aaaa_aaaa, 24'd176}, 1'b0, '0},
    '{'{ACT_EMIT, STREAM_VIDEO, 1'b0, 1'b1, 33'd1, 24'd177}, 1'b0, '0},
    // no PCR just above and below a full payload, then PMT with and without PCR
    '{'{ACT_EMIT, STREAM_AUDIO, 1'b1, 1'b0, 33'd0, 24'd185}, 1'b0, '0},
    '{'{ACT_EMIT, STREAM_AUDIO, 1'b0, 1'b0, 33'd0, 24'd182}, 1'b0, '0},
    '{'{ACT_EMIT, STREAM_PMT, 1'b1, 1'b1, 33'h1_0000_0000, 24'd8}, 1'b0, '0},
    '{'{ACT_EMIT, STREAM_PMT, 1'b0, 1'b0, 33'd0, 24'h80_0000}, 1'b0, '0},
    // second restart, then audio counter starts from zero again
    '{'{ACT_RESTART, STREAM_PAT, 1'b0, 1'b0, 33'd0, 24'd0}, 1'b0, '0},
    '{'{ACT_EMIT, STREAM_AUDIO, 1'b1, 1'b0, 33'd0, 24'd184}, 1'b1,
      '{32'h4741_0110, 8'd0, 1'b0, 8'h00, 48'd0, 8'd4, 8'd184}}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PID_W-1:0] cfg_data;

  tsph_in_if  in_ch ();
  tsph_out_if out_ch ();

  ts_packet_header_formatter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block's state: PID registers by register index and the
  // per-stream continuity counters.
  logic [PID_W-1:0] pid_mirror [3];
  logic [CC_W-1:0]  cc_count [STREAMS];

  stim_row_t stim_q [$];
  out_word_t pending_headers [$];
  stim_row_t offer;
  bit        offer_live;
  bit        idle_on;
  bit        hold_ask;
  int        err_count;
  int        gap_left;
  int        stall_left;
  int        hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build the header for one emit request and advance its stream's counter.
  function automatic out_word_t format_header(input in_word_t req);
    out_word_t       r;
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    logic [1:0]       afc;
    logic             present;
    int unsigned      rem, cap, afl, offset, taken;
    r = '0;
    case (req.stream_select)
      STREAM_PMT:   pid = pid_mirror[REG_PMT_PID];
      STREAM_VIDEO: pid = pid_mirror[REG_VIDEO_PID];
      STREAM_AUDIO: pid = pid_mirror[REG_AUDIO_PID];
      default:      pid = PAT_PID;
    endcase
    cc = cc_count[req.stream_select];
    cc_count[req.stream_select] = cc + 1'b1;

    rem = req.bytes_remaining;
    cap = PACKET_LEN - HDR_BYTES;
    afl = 0;
    present = 1'b0;
    if (req.carry_pcr) begin
      // flags and PCR; stuff the rest when the payload falls short
      afl = PCR_AF_BYTES;
      if (rem < cap - 8) afl += cap - 8 - rem;
      present = 1'b1;
      r.adapt_flags = FLAGS_PCR;
      r.pcr_field = {req.clock_base, 15'd0};
    end else if (rem < cap) begin
      afl = cap - rem - 1;
      present = 1'b1;
    end
    offset = HDR_BYTES;
    if (present) begin
      offset = HDR_BYTES + 1 + afl;
      cap = PACKET_LEN - offset;
    end
    taken = (rem < cap) ? rem : cap;

    if (taken == 0) afc = AFC_ADAPT;
    else if (present) afc = AFC_BOTH;
    else afc = AFC_PAYLOAD;

    r.header_word = {SYNC_BYTE, 1'b0, req.unit_start, 1'b0, pid, 2'b00, afc, cc};
    r.adapt_length = afl[BYTE_W-1:0];
    r.adapt_present = present;
    r.payload_start = offset[BYTE_W-1:0];
    r.payload_taken = taken[BYTE_W-1:0];
    return r;
  endfunction

  // Random request; remaining counts lean toward the capacity boundaries.
  function automatic in_word_t random_request();
    in_word_t    r;
    int unsigned pick;
    r.action = ($urandom_range(0, 49) == 0) ? ACT_RESTART : ACT_EMIT;
    r.stream_select = SEL_W'($urandom_range(0, 3));
    r.unit_start = 1'($urandom_range(0, 1));
    r.carry_pcr = 1'($urandom_range(0, 1));
    r.clock_base = {1'($urandom_range(0, 1)), $urandom()};
    pick = $urandom_range(0, 9);
    if (pick < 4) r.bytes_remaining = REM_W'($urandom_range(0, 200));
    else if (pick < 6) r.bytes_remaining = REM_W'(REM_EDGES[$urandom_range(0, 8)]);
    else r.bytes_remaining = REM_W'($urandom());
    return r;
  endfunction

  task automatic queue_random(input int count);
    stim_row_t row;
    for (int i = 0; i < count; i++) begin
      row.req = random_request();
      row.typed = 1'b0;
      row.want = '0;
      stim_q.push_back(row);
    end
  endtask

  // Hold until every request is accepted and every header has come back,
  // then give a trailing restart time to clear the pipeline.
  task automatic wait_for_idle();
    while (stim_q.size() != 0 || offer_live || pending_headers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PID_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx != REG_UNUSED) pid_mirror[idx] = value;
  endtask

  task automatic compare_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  // Request side: take the accepted word into the predictor, then either
  // hold the current offer, idle for a burst, or present the next word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (offer.req.action == ACT_RESTART) begin
          cc_count = '{default: '0};
        end else if (offer.typed) begin
          // advance the counter state, keep the typed header
          void'(format_header(offer.req));
          pending_headers.push_back(offer.want);
        end else begin
          pending_headers.push_back(format_header(offer.req));
        end
        offer_live = 1'b0;
      end
      if (!offer_live) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (idle_on && stim_q.size() != 0 && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          in_ch.valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          offer = stim_q.pop_front();
          offer_live = 1'b1;
          in_ch.action <= offer.req.action;
          in_ch.stream_select <= offer.req.stream_select;
          in_ch.unit_start <= offer.req.unit_start;
          in_ch.carry_pcr <= offer.req.carry_pcr;
          in_ch.clock_base <= offer.req.clock_base;
          in_ch.bytes_remaining <= offer.req.bytes_remaining;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each accepted header against the oldest expectation,
  // then decide ready for the next cycle (long hold, stall burst or open).
  always @(posedge clk) begin : result_side
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.header_word = out_ch.header_word;
        got.adapt_length = out_ch.adapt_length;
        got.adapt_present = out_ch.adapt_present;
        got.adapt_flags = out_ch.adapt_flags;
        got.pcr_field = out_ch.pcr_field;
        got.payload_start = out_ch.payload_start;
        got.payload_taken = out_ch.payload_taken;
        if (pending_headers.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected header, expected none actual %0h",
                   $time, got.header_word);
        end else begin
          want = pending_headers.pop_front();
          compare_field("header_word", want.header_word, got.header_word);
          compare_field("adapt_length", want.adapt_length, got.adapt_length);
          compare_field("adapt_present", want.adapt_present, got.adapt_present);
          compare_field("adapt_flags", want.adapt_flags, got.adapt_flags);
          compare_field("pcr_field", want.pcr_field, got.pcr_field);
          compare_field("payload_start", want.payload_start, got.payload_start);
          compare_field("payload_taken", want.payload_taken, got.payload_taken);
        end
      end
      if (hold_ask) begin
        hold_left = LONG_HOLD;
        hold_ask = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_EMIT;
    in_ch.stream_select = STREAM_PAT;
    in_ch.unit_start = 1'b0;
    in_ch.carry_pcr = 1'b0;
    in_ch.clock_base = '0;
    in_ch.bytes_remaining = '0;
    out_ch.ready = 1'b0;
    pid_mirror[REG_PMT_PID] = PMT_PID_RST;
    pid_mirror[REG_VIDEO_PID] = VIDEO_PID_RST;
    pid_mirror[REG_AUDIO_PID] = AUDIO_PID_RST;
    cc_count = '{default: '0};
    offer = '0;
    offer_live = 1'b0;
    idle_on = 1'b1;
    hold_ask = 1'b0;
    err_count = 0;
    gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    quiet_cycles = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under reset PIDs.
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    wait_for_idle();

    // Largest PIDs; the write past the last register must be dropped.
    write_reg(REG_PMT_PID, PID_MAX);
    write_reg(REG_VIDEO_PID, PID_MAX);
    write_reg(REG_AUDIO_PID, PID_MAX);
    write_reg(REG_UNUSED, 13'd0);
    queue_random(PHASE_WORDS);
    wait_for_idle();

    // Zero PIDs. Hold the result side off while requests keep coming, so
    // the block fills and stalls its input.
    write_reg(REG_PMT_PID, '0);
    write_reg(REG_VIDEO_PID, '0);
    write_reg(REG_AUDIO_PID, '0);
    hold_ask = 1'b1;
    queue_random(HOLD_WORDS);
    wait_for_idle();
    queue_random(PHASE_WORDS - HOLD_WORDS);
    wait_for_idle();

    // Random PIDs.
    write_reg(REG_PMT_PID, PID_W'($urandom_range(0, 8191)));
    write_reg(REG_VIDEO_PID, PID_W'($urandom_range(0, 8191)));
    write_reg(REG_AUDIO_PID, PID_W'($urandom_range(0, 8191)));
    queue_random(PHASE_WORDS);
    wait_for_idle();

    // Last stretch at full rate with fresh PIDs and no idling on either side.
    write_reg(REG_UNUSED, PID_W'($urandom_range(0, 8191)));
    write_reg(REG_PMT_PID, PID_W'($urandom_range(0, 8191)));
    write_reg(REG_VIDEO_PID, PID_W'($urandom_range(0, 8191)));
    write_reg(REG_AUDIO_PID, PID_W'($urandom_range(0, 8191)));
    idle_on = 1'b0;
    queue_random(PHASE_WORDS);
    wait_for_idle();
    repeat (8) @(posedge clk);

    if (pending_headers.size() != 0) begin
      err_count++;
      $display("%0t ns: headers never arrived, expected %0d actual 0",
               $time, pending_headers.size());
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/tsph_pkg.sv
design/tsph_in_if.sv
design/tsph_out_if.sv
design/tsph_cfg_regs.sv
design/tsph_cc_bank.sv
design/tsph_fmt.sv
design/ts_packet_header_formatter.sv
tb/ts_packet_header_formatter_tb.sv
